// ----- rtl/sitdt_pkg.sv -----
// ============================================================================
// sitdt_pkg - shared types and constants
// Types and character codes for the signed integer to decimal text converter.
// ============================================================================
`default_nettype none

package sitdt_pkg;

    localparam int VALUE_W    = 32;
    localparam int BCD_DIGITS = 10;
    localparam int LIMIT_W    = 6;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

    // Result of the binary to BCD pass, handed to the output sequencer.
    typedef struct packed {
        logic done;
        bcd_t digits;
    } bcd_res_t;

endpackage

`default_nettype wire

// ----- rtl/sitdt_bcd.sv -----
// ============================================================================
// sitdt_bcd - bit-serial binary to BCD converter
// Shift-and-add-3 conversion, one magnitude bit per cycle.
// ============================================================================
`default_nettype none

module sitdt_bcd (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire logic [sitdt_pkg::VALUE_W-1:0] mag,
    output sitdt_pkg::bcd_res_t                res
);
    import sitdt_pkg::*;

    localparam int CNT_W = $clog2(VALUE_W);

    logic [VALUE_W-1:0]      bin_reg, bin_next;
    bcd_t                    bcd_reg, bcd_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    run_reg, run_next;
    logic                    done_reg, done_next;
    bcd_t                    adj;
    logic [BCD_DIGITS*4-1:0] adj_bits;

    // Add 3 to every digit of 5 or more before the shift.
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[i] >= 4'd5)
                adj[i] = bcd_reg[i] + 4'd3;
            else
                adj[i] = bcd_reg[i];
        end
    end

    assign adj_bits = adj;

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (load)
        begin
            bin_next = mag;
            bcd_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            bcd_next = {adj_bits[BCD_DIGITS*4-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VALUE_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign res.done   = done_reg;
    assign res.digits = bcd_reg;

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg)
        else $error("done raised while conversion still running");

    a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> run_reg && cnt_reg == '0)
        else $error("load did not start a conversion");

    a_run_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg && !load && cnt_reg == CNT_W'(VALUE_W - 1) |=> done_reg)
        else $error("conversion end without done");

endmodule

`default_nettype wire

// ----- rtl/signed_int_to_decimal_text.sv -----
// ============================================================================
// signed_int_to_decimal_text - signed 32-bit integer to decimal ASCII text
// Converts one value per transaction into a '-' for negatives, digits and a NUL terminator,
// or a single error result when the text does not fit the buffer limit.
// ============================================================================
// Sequence: the serial BCD pass and length check give either the error result or,
//   after the '-' for negatives, the digits and the terminator, one char per cycle.
// Transactions do not overlap: busy drops in the cycle the final result is shown, so
//   the next start can be taken there.
// Results cannot be stalled: each is shown for one cycle under strobe.
// Reset: returns to idle, buffer_limit reads 32.
`default_nettype none

module signed_int_to_decimal_text (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output      logic                          busy,
    input  wire logic signed [sitdt_pkg::VALUE_W-1:0] value,
    output      logic                          strobe,
    output      logic [7:0]                    character,
    output      logic                          last,
    output      logic                          status,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output      logic [31:0]                   prdata,
    output      logic                          pready
);
    import sitdt_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CONV   = 3'd1;
    localparam logic [2:0] ST_SIGN   = 3'd2;
    localparam logic [2:0] ST_DIGITS = 3'd3;
    localparam logic [2:0] ST_TERM   = 3'd4;

    localparam logic REG_LIMIT = 1'b0;

    logic [2:0]         state_reg, state_next;
    logic               neg_reg, neg_next;
    logic [3:0]         idx_reg, idx_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic               strobe_reg, strobe_next;
    logic [7:0]         char_reg, char_next;
    logic               last_reg, last_next;
    logic               status_reg, status_next;

    logic               accept;
    logic [VALUE_W-1:0] mag;
    bcd_res_t           bres;
    logic [3:0]         nd;
    logic [3:0]         text_len;
    logic               too_long;

    assign accept = start && !busy;
    assign mag    = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;

    sitdt_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .mag   (mag),
        .res   (bres)
    );

    // Significant digit count, at least one.
    always_comb
    begin
        nd = 4'd1;
        for (int i = 1; i < BCD_DIGITS; i++)
        begin
            if (bres.digits[i] != 4'd0)
                nd = 4'(i + 1);
        end
    end

    assign text_len = nd + {3'b0, neg_reg};
    assign too_long = {2'b0, text_len} >= limit_reg;

    always_comb
    begin
        state_next  = state_reg;
        neg_next    = neg_reg;
        idx_next    = idx_reg;
        strobe_next = 1'b0;
        char_next   = CHAR_NUL;
        last_next   = 1'b0;
        status_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = value[VALUE_W-1];
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (bres.done)
                begin
                    idx_next = nd - 4'd1;
                    if (too_long)
                    begin
                        strobe_next = 1'b1;
                        last_next   = 1'b1;
                        status_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else if (neg_reg)
                        state_next = ST_SIGN;
                    else
                        state_next = ST_DIGITS;
                end
            end
            ST_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = CHAR_MINUS;
                state_next  = ST_DIGITS;
            end
            ST_DIGITS:
            begin
                strobe_next = 1'b1;
                char_next   = CHAR_ZERO + {4'b0, bres.digits[idx_reg]};
                if (idx_reg == 4'd0)
                    state_next = ST_TERM;
                else
                    idx_next = idx_reg - 4'd1;
            end
            ST_TERM:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            limit_reg  <= LIMIT_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            if (psel && penable && pwrite && pready && paddr[2] == REG_LIMIT)
                limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        idx_reg    <= idx_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    assign busy      = state_reg != ST_IDLE;
    assign strobe    = strobe_reg;
    assign character = char_reg;
    assign last      = last_reg;
    assign status    = status_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_LIMIT) ? {{(32-LIMIT_W){1'b0}}, limit_reg} : 32'd0;

    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("gap inside a character run");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status |-> last && character == CHAR_NUL)
        else $error("malformed error result");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !busy)
        else $error("still busy on final result");

    a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && !strobe)
        else $error("result during conversion start");

endmodule

`default_nettype wire
